// File: src/rsi_pkg.sv
// Shared types and constants for the ray / square intersection pipeline.
// Used by every module in src; depends on nothing.
package rsi_pkg;

    localparam int PW     = 20;          // position width, Q10.10
    localparam int DFB    = 18;          // direction fraction bits
    localparam int DW     = DFB + 2;     // direction width
    localparam int DEN_W  = 2 * DW + 2;  // n.d sum width
    localparam int NUM_W  = PW + DW + 3; // (c-o).n sum width
    localparam int Q_W    = 31;          // quotient bits kept before saturation
    localparam int SAT_SH = Q_W - DFB;   // |num| >= |den| << SAT_SH means t >= 2^Q_W
    localparam int PR_W   = DW + Q_W + 1;   // d * t product width
    localparam int P_W    = PR_W - DFB + 1; // unsaturated hit point width
    localparam int V_W    = P_W + 1;        // c - p width
    localparam int VU_W   = V_W + DW;       // (c-p) * axis width
    localparam int DU_W   = VU_W + 2;       // sum of three of those
    localparam int CFG_W  = 3 * PW;
    localparam int IDX_W  = 3;

    localparam logic [Q_W-1:0] T_CAP = Q_W'(64'd1 << 30);

    typedef enum logic [IDX_W-1:0] {
        CFG_CENTER = 3'd0,
        CFG_NORMAL = 3'd1,
        CFG_UP     = 3'd2,
        CFG_RIGHT  = 3'd3,
        CFG_HALF   = 3'd4,
        CFG_DEPS   = 3'd5,
        CFG_TEPS   = 3'd6
    } t_cfg_idx;

    typedef logic signed [PW-1:0] t_pos;
    typedef logic signed [DW-1:0] t_dir;

    typedef struct packed {
        logic                    miss;
        t_pos [2:0]              o;
        t_dir [2:0]              d;
        logic [NUM_W-1:0]        num_mag;
        logic [DEN_W-1:0]        den_mag;
    } t_dv;

    typedef struct packed {
        logic                    miss;
        t_pos [2:0]              o;
        t_dir [2:0]              d;
        logic                    sat;
        logic [Q_W-1:0]          q;
    } t_dq;

endpackage

// File: src/rsi_dot.sv
// Front end: forms n.d and (c-o).n over three stages, checks the
// denominator, a zero numerator and the sign of t. Depends on rsi_pkg.
module rsi_dot import rsi_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_pos [2:0]       i_o,
    input  t_dir [2:0]       i_d,
    input  t_pos [2:0]       i_c,
    input  t_dir [2:0]       i_n,
    input  logic [DFB-1:0]   i_deps,
    output logic             o_valid,
    input  logic             i_ready,
    output t_dv              o_data
);

    logic [2:0]               r_v;
    logic [3:0]               w_rdy;

    t_pos [2:0]               r_a_o, r_b_o, r_c_o;
    t_dir [2:0]               r_a_d, r_b_d, r_c_d;
    logic signed [2*DW-1:0]   r_a_nd [3];
    logic signed [PW:0]       r_a_co [3];
    logic signed [DEN_W-1:0]  r_b_den;
    logic signed [PW+DW:0]    r_b_cn [3];

    logic signed [NUM_W-1:0]  n_num;
    logic [NUM_W-1:0]         n_num_mag;
    logic [DEN_W-1:0]         n_den_mag;
    logic                     n_miss;
    logic                     r_c_miss;
    logic [NUM_W-1:0]         r_c_num_mag;
    logic [DEN_W-1:0]         r_c_den_mag;

    assign w_rdy[3] = i_ready;
    assign w_rdy[2] = !r_v[2] || w_rdy[3];
    assign w_rdy[1] = !r_v[1] || w_rdy[2];
    assign w_rdy[0] = !r_v[0] || w_rdy[1];
    assign o_ready  = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) r_v[0] <= i_valid;
            if (w_rdy[1]) r_v[1] <= r_v[0];
            if (w_rdy[2]) r_v[2] <= r_v[1];
        end
    end

    always_comb begin
        n_num = NUM_W'(r_b_cn[0]) + NUM_W'(r_b_cn[1]) + NUM_W'(r_b_cn[2]);
        n_num_mag = n_num[NUM_W-1] ? NUM_W'(-n_num) : NUM_W'(n_num);
        n_den_mag = r_b_den[DEN_W-1] ? DEN_W'(-r_b_den) : DEN_W'(r_b_den);
        n_miss = (n_den_mag <= DEN_W'({i_deps, {DFB{1'b0}}}))
              || (n_num == '0)
              || (n_num[NUM_W-1] != r_b_den[DEN_W-1]);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_a_o <= i_o;
            r_a_d <= i_d;
            for (int k = 0; k < 3; k++) begin
                r_a_nd[k] <= (2*DW)'($signed(i_n[k]) * $signed(i_d[k]));
                r_a_co[k] <= (PW+1)'($signed(i_c[k]) - $signed(i_o[k]));
            end
        end
        if (w_rdy[1]) begin
            r_b_o   <= r_a_o;
            r_b_d   <= r_a_d;
            r_b_den <= DEN_W'(r_a_nd[0]) + DEN_W'(r_a_nd[1]) + DEN_W'(r_a_nd[2]);
            for (int k = 0; k < 3; k++) begin
                r_b_cn[k] <= (PW+DW+1)'(r_a_co[k] * $signed(i_n[k]));
            end
        end
        if (w_rdy[2]) begin
            r_c_o       <= r_b_o;
            r_c_d       <= r_b_d;
            r_c_miss    <= n_miss;
            r_c_num_mag <= n_num_mag;
            r_c_den_mag <= n_den_mag;
        end
    end

    assign o_valid         = r_v[2];
    assign o_data.miss     = r_c_miss;
    assign o_data.o        = r_c_o;
    assign o_data.d        = r_c_d;
    assign o_data.num_mag  = r_c_num_mag;
    assign o_data.den_mag  = r_c_den_mag;

endmodule

// File: src/rsi_div.sv
// Restoring divider, one quotient bit per stage: t = |num| * 2^DFB / |den|.
// Flags a quotient of 2^Q_W or more as saturated. Depends on rsi_pkg.
module rsi_div import rsi_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_dv     i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_dq     o_data
);

    localparam int NS = Q_W + 1;

    logic [NS-1:0]       r_v;
    logic [NS:0]         w_rdy;
    t_dv                 r_pl  [NS];
    logic                r_sat [NS];
    logic [DEN_W-1:0]    r_rem [NS];
    logic [Q_W-1:0]      r_q   [NS];

    assign w_rdy[NS] = i_ready;
    assign o_ready   = w_rdy[0];

    genvar j;
    generate
        for (j = 0; j < NS; j++) begin : g_rdy
            assign w_rdy[j] = !r_v[j] || w_rdy[j+1];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (w_rdy[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // Head: overflow check and the partial remainder above the kept quotient bits
    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_pl[0]  <= i_data;
            r_sat[0] <= (DEN_W+SAT_SH)'(i_data.num_mag)
                     >= (DEN_W+SAT_SH)'({i_data.den_mag, {SAT_SH{1'b0}}});
            r_rem[0] <= DEN_W'(i_data.num_mag[NUM_W-1:SAT_SH]);
            r_q[0]   <= '0;
        end
    end

    generate
        for (j = 1; j < NS; j++) begin : g_bit
            localparam int BI = Q_W - j;
            logic             w_in;
            logic [DEN_W:0]   w_rem2;
            logic [DEN_W:0]   w_diff;
            logic             w_ge;
            logic [DEN_W-1:0] n_rem;
            logic [Q_W-1:0]   n_q;

            if (BI >= DFB) begin : g_num
                assign w_in = r_pl[j-1].num_mag[BI-DFB];
            end else begin : g_zero
                assign w_in = 1'b0;
            end

            always_comb begin
                w_rem2 = {r_rem[j-1], w_in};
                w_diff = w_rem2 - {1'b0, r_pl[j-1].den_mag};
                w_ge   = w_rem2 >= {1'b0, r_pl[j-1].den_mag};
                n_rem  = w_ge ? w_diff[DEN_W-1:0] : w_rem2[DEN_W-1:0];
                n_q    = r_q[j-1];
                n_q[BI] = w_ge;
            end

            always_ff @(posedge i_clk) begin
                if (w_rdy[j]) begin
                    r_pl[j]  <= r_pl[j-1];
                    r_sat[j] <= r_sat[j-1];
                    r_rem[j] <= n_rem;
                    r_q[j]   <= n_q;
                end
            end
        end
    endgenerate

    assign o_valid     = r_v[NS-1];
    assign o_data.miss = r_pl[NS-1].miss;
    assign o_data.o    = r_pl[NS-1].o;
    assign o_data.d    = r_pl[NS-1].d;
    assign o_data.sat  = r_sat[NS-1];
    assign o_data.q    = r_q[NS-1];

endmodule

// File: src/rsi_point.sv
// Back end: t threshold, hit point o + d*t, projection on up and right,
// square bounds and output saturation, five stages. Depends on rsi_pkg.
module rsi_point import rsi_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_dq              i_data,
    input  t_pos [2:0]       i_c,
    input  t_dir [2:0]       i_u,
    input  t_dir [2:0]       i_r,
    input  logic [PW-1:0]    i_half,
    input  logic [PW-1:0]    i_teps,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_is_hit,
    output logic [PW-1:0]    o_dist,
    output t_pos [2:0]       o_pt
);

    logic [4:0]              r_v;
    logic [5:0]              w_rdy;

    logic                    r_miss [4];
    logic [PW-1:0]           r_dist [4];
    t_pos [2:0]              r_o0, r_o1;
    t_dir [2:0]              r_d0;
    logic [Q_W-1:0]          r_tq;
    logic signed [PR_W-1:0]  r_prod [3];
    logic signed [P_W-1:0]   r_p    [3];
    logic signed [V_W-1:0]   r_vv   [3];
    logic signed [VU_W-1:0]  r_vu   [3];
    logic signed [VU_W-1:0]  r_vr   [3];
    t_pos [2:0]              r_psat;

    logic                    n_miss0;
    logic [Q_W-1:0]          n_tq;
    logic [PW-1:0]           n_dist;
    logic signed [DU_W-1:0]  n_du, n_dr;
    logic [DU_W-1:0]         n_du_mag, n_dr_mag;
    logic                    n_hit;
    logic signed [P_W-1:0]   w_pmax, w_pmin;

    logic                    r_hit;
    logic [PW-1:0]           r_out_dist;
    t_pos [2:0]              r_out_pt;

    assign w_rdy[5] = i_ready;
    assign w_rdy[4] = !r_v[4] || w_rdy[5];
    assign w_rdy[3] = !r_v[3] || w_rdy[4];
    assign w_rdy[2] = !r_v[2] || w_rdy[3];
    assign w_rdy[1] = !r_v[1] || w_rdy[2];
    assign w_rdy[0] = !r_v[0] || w_rdy[1];
    assign o_ready  = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) r_v[0] <= i_valid;
            for (int k = 1; k < 5; k++) begin
                if (w_rdy[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    assign w_pmax = P_W'({1'b0, {(PW-1){1'b1}}});
    assign w_pmin = -w_pmax - P_W'(1);

    always_comb begin
        n_miss0 = i_data.miss || (!i_data.sat && (i_data.q <= Q_W'(i_teps)));
        if (i_data.sat || i_data.q > T_CAP) begin
            n_tq = T_CAP;
        end else begin
            n_tq = i_data.q;
        end
        if (i_data.sat || i_data.q > Q_W'({PW{1'b1}})) begin
            n_dist = '1;
        end else begin
            n_dist = i_data.q[PW-1:0];
        end

        n_du = DU_W'(r_vu[0]) + DU_W'(r_vu[1]) + DU_W'(r_vu[2]);
        n_dr = DU_W'(r_vr[0]) + DU_W'(r_vr[1]) + DU_W'(r_vr[2]);
        n_du_mag = n_du[DU_W-1] ? DU_W'(-n_du) : DU_W'(n_du);
        n_dr_mag = n_dr[DU_W-1] ? DU_W'(-n_dr) : DU_W'(n_dr);
        n_hit = !r_miss[3]
             && (n_du_mag <= DU_W'({i_half, {DFB{1'b0}}}))
             && (n_dr_mag <= DU_W'({i_half, {DFB{1'b0}}}));
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_miss[0] <= n_miss0;
            r_dist[0] <= n_dist;
            r_o0      <= i_data.o;
            r_d0      <= i_data.d;
            r_tq      <= n_tq;
        end
        if (w_rdy[1]) begin
            r_miss[1] <= r_miss[0];
            r_dist[1] <= r_dist[0];
            r_o1      <= r_o0;
            for (int k = 0; k < 3; k++) begin
                r_prod[k] <= PR_W'($signed(r_d0[k]) * $signed({1'b0, r_tq}));
            end
        end
        if (w_rdy[2]) begin
            r_miss[2] <= r_miss[1];
            r_dist[2] <= r_dist[1];
            for (int k = 0; k < 3; k++) begin
                // arithmetic shift rounds toward minus infinity
                r_p[k]  <= P_W'($signed(r_o1[k]) + (r_prod[k] >>> DFB));
                r_vv[k] <= V_W'($signed(i_c[k]) - $signed(r_o1[k])
                               - (r_prod[k] >>> DFB));
            end
        end
        if (w_rdy[3]) begin
            r_miss[3] <= r_miss[2];
            r_dist[3] <= r_dist[2];
            for (int k = 0; k < 3; k++) begin
                r_vu[k] <= VU_W'(r_vv[k] * $signed(i_u[k]));
                r_vr[k] <= VU_W'(r_vv[k] * $signed(i_r[k]));
                if (r_p[k] > w_pmax) begin
                    r_psat[k] <= t_pos'(w_pmax[PW-1:0]);
                end else if (r_p[k] < w_pmin) begin
                    r_psat[k] <= t_pos'(w_pmin[PW-1:0]);
                end else begin
                    r_psat[k] <= t_pos'(r_p[k][PW-1:0]);
                end
            end
        end
        if (w_rdy[4]) begin
            r_hit      <= n_hit;
            r_out_dist <= n_hit ? r_dist[3] : '0;
            r_out_pt   <= n_hit ? r_psat : '0;
        end
    end

    assign o_valid  = r_v[4];
    assign o_is_hit = r_hit;
    assign o_dist   = r_out_dist;
    assign o_pt     = r_out_pt;

endmodule

// File: src/ray_square_intersect.sv
// Ray / square intersection, one ray per transaction, one result per ray.
// Pipeline: 3 dot-product stages, 32 divider stages, 5 point stages.
// Throughput: one ray per cycle without back-pressure; the 32-stage restoring divider (a head
// stage, then one quotient bit per stage) sets the depth. Each stage holds under back-pressure.
// Reset (synchronous, active low) empties the pipeline and loads the default
// square: half size 1.0 in the z = 0 plane facing +z, centered at the origin.
module ray_square_intersect import rsi_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (20 bits each, low first)
    input  logic [6*PW-1:0]    i_s_tdata,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    // hit_distance, point_x, point_y, point_z (20 bits each, low first)
    output logic [4*PW-1:0]    o_m_tdata,
    // is_hit
    output logic [0:0]         o_m_tuser,
    input  logic               i_cfg_we,
    input  logic [IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    logic [3*PW-1:0]  r_center;
    logic [3*DW-1:0]  r_normal, r_up, r_right;
    logic [PW-1:0]    r_half, r_teps;
    logic [DFB-1:0]   r_deps;

    t_pos [2:0]       w_o, w_c, w_pt;
    t_dir [2:0]       w_d, w_n, w_u, w_r;
    t_dv              w_dv;
    t_dq              w_dq;
    logic             w_dv_valid, w_dv_ready, w_dq_valid, w_dq_ready;
    logic             w_hit;
    logic [PW-1:0]    w_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= '0;
            r_normal <= (3*DW)'(1) << (2*DW + DFB);
            r_up     <= (3*DW)'(1) << (DW + DFB);
            r_right  <= (3*DW)'(1) << DFB;
            r_half   <= PW'(1) << 10;
            r_deps   <= DFB'(1);
            r_teps   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CENTER: r_center <= i_cfg_data[3*PW-1:0];
                CFG_NORMAL: r_normal <= i_cfg_data[3*DW-1:0];
                CFG_UP:     r_up     <= i_cfg_data[3*DW-1:0];
                CFG_RIGHT:  r_right  <= i_cfg_data[3*DW-1:0];
                CFG_HALF:   r_half   <= i_cfg_data[PW-1:0];
                CFG_DEPS:   r_deps   <= i_cfg_data[DFB-1:0];
                CFG_TEPS:   r_teps   <= i_cfg_data[PW-1:0];
                default: ;  // drop writes past the last register
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_o[k] = t_pos'(i_s_tdata[k*PW +: PW]);
            w_d[k] = t_dir'(i_s_tdata[3*PW + k*DW +: DW]);
            w_c[k] = t_pos'(r_center[k*PW +: PW]);
            w_n[k] = t_dir'(r_normal[k*DW +: DW]);
            w_u[k] = t_dir'(r_up[k*DW +: DW]);
            w_r[k] = t_dir'(r_right[k*DW +: DW]);
        end
    end

    rsi_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_o     (w_o),
        .i_d     (w_d),
        .i_c     (w_c),
        .i_n     (w_n),
        .i_deps  (r_deps),
        .o_valid (w_dv_valid),
        .i_ready (w_dv_ready),
        .o_data  (w_dv)
    );

    rsi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_dv_valid),
        .o_ready (w_dv_ready),
        .i_data  (w_dv),
        .o_valid (w_dq_valid),
        .i_ready (w_dq_ready),
        .o_data  (w_dq)
    );

    rsi_point u_point (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_dq_valid),
        .o_ready  (w_dq_ready),
        .i_data   (w_dq),
        .i_c      (w_c),
        .i_u      (w_u),
        .i_r      (w_r),
        .i_half   (r_half),
        .i_teps   (r_teps),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_is_hit (w_hit),
        .o_dist   (w_dist),
        .o_pt     (w_pt)
    );

    assign o_m_tuser = w_hit;
    assign o_m_tdata = {w_pt[2], w_pt[1], w_pt[0], w_dist};

endmodule

// File: sim/tb.sv
// Testbench for ray_square_intersect: streams rays through the block under several square
// settings and checks each hit record against a listed expectation or an in-bench
// fixed-point predictor. Depends on rsi_pkg and ray_square_intersect from src.
`timescale 1ns / 100ps

module tb;
    import rsi_pkg::*;

    typedef struct packed {
        logic          is_hit;
        logic [PW-1:0] hdist;
        logic [PW-1:0] px;
        logic [PW-1:0] py;
        logic [PW-1:0] pz;
    } t_hit;

    typedef struct {
        logic [6*PW-1:0] ray;
        logic            known;
        t_hit            hit;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_s_tvalid = 1'b0;
    logic               o_s_tready;
    logic [6*PW-1:0]    i_s_tdata = '0;
    logic               o_m_tvalid;
    logic               i_m_tready = 1'b0;
    logic [4*PW-1:0]    o_m_tdata;
    logic [0:0]         o_m_tuser;
    logic               i_cfg_we = 1'b0;
    logic [IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_W-1:0]   i_cfg_data = '0;

    ray_square_intersect dut (.*);

    always #5 i_clk = ~i_clk;

    // square settings held by the predictor
    logic [CFG_W-1:0] sq_center, sq_normal, sq_up, sq_right;
    logic [PW-1:0]    sq_half, sq_teps;
    logic [DFB-1:0]   sq_deps;

    t_hit   hits_due[$];
    int     n_fail = 0;
    int     idle_pct = 0, stall_pct = 0;
    int     quiet = 0;
    localparam int QUIET_LIMIT = 20000;

    function automatic longint sx(input logic [63:0] v, input int w);
        logic [63:0] m;
        m = 64'd1 << (w - 1);
        return longint'((v & ((m << 1) - 1)) ^ m) - longint'(m);
    endfunction

    function automatic longint floor_shr(input longint x, input int s);
        return x >>> s;
    endfunction

    function automatic longint clamp_pos(input longint x);
        longint hi;
        hi = (longint'(1) <<< (PW - 1)) - 1;
        return x > hi ? hi : (x < -hi - 1 ? -hi - 1 : x);
    endfunction

    function automatic t_hit trace_ray(input logic [6*PW-1:0] ray);
        longint o[3], d[3], c[3], n[3], u[3], r[3], p[3];
        longint den, num, du, dr, tq, v, lim;
        logic [63:0] tmag, nm, dm;
        t_hit h;
        h = '0;
        den = 0; num = 0; du = 0; dr = 0;
        for (int k = 0; k < 3; k++) begin
            o[k] = sx(ray[k*PW +: PW], PW);
            d[k] = sx(ray[(3+k)*PW +: PW], DW);
            c[k] = sx(sq_center[k*PW +: PW], PW);
            n[k] = sx(sq_normal[k*DW +: DW], DW);
            u[k] = sx(sq_up[k*DW +: DW], DW);
            r[k] = sx(sq_right[k*DW +: DW], DW);
            den += n[k] * d[k];
            num += (c[k] - o[k]) * n[k];
        end
        dm = den < 0 ? -den : den;
        nm = num < 0 ? -num : num;
        if (dm <= (64'(sq_deps) << DFB)) return h;
        if (num == 0 || ((num < 0) != (den < 0))) return h;
        tmag = (nm << DFB) / dm;
        if (tmag <= 64'(sq_teps)) return h;
        tq = tmag > (64'd1 << 30) ? (longint'(1) <<< 30) : longint'(tmag);
        for (int k = 0; k < 3; k++) begin
            p[k] = o[k] + floor_shr(d[k] * tq, DFB);
            v = c[k] - p[k];
            du += v * u[k];
            dr += v * r[k];
        end
        lim = longint'(sq_half) <<< DFB;
        if ((du < 0 ? -du : du) > lim || (dr < 0 ? -dr : dr) > lim) return h;
        h.is_hit = 1'b1;
        h.hdist = tmag > 64'((1 << PW) - 1) ? '1 : tmag[PW-1:0];
        h.px = PW'(clamp_pos(p[0]));
        h.py = PW'(clamp_pos(p[1]));
        h.pz = PW'(clamp_pos(p[2]));
        return h;
    endfunction

    function automatic logic [CFG_W-1:0] vec3(input longint x, input longint y,
                                              input longint z, input int w);
        logic [CFG_W-1:0] q;
        q = '0;
        q[0 +: PW] = PW'(x);
        if (w == DW) begin
            q[DW +: DW] = DW'(y);
            q[2*DW +: DW] = DW'(z);
        end else begin
            q[PW +: PW] = PW'(y);
            q[2*PW +: PW] = PW'(z);
        end
        return q;
    endfunction

    function automatic logic [6*PW-1:0] mk_ray(input longint ox, input longint oy,
            input longint oz, input longint dx, input longint dy, input longint dz);
        return {PW'(dz), PW'(dy), PW'(dx), PW'(oz), PW'(oy), PW'(ox)};
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_CENTER: sq_center = val;
            CFG_NORMAL: sq_normal = val & {{(CFG_W-3*DW){1'b0}}, {(3*DW){1'b1}}};
            CFG_UP:     sq_up = val & {{(CFG_W-3*DW){1'b0}}, {(3*DW){1'b1}}};
            CFG_RIGHT:  sq_right = val & {{(CFG_W-3*DW){1'b0}}, {(3*DW){1'b1}}};
            CFG_HALF:   sq_half = val[PW-1:0];
            CFG_DEPS:   sq_deps = val[DFB-1:0];
            CFG_TEPS:   sq_teps = val[PW-1:0];
            default: ;
        endcase
    endtask

    // drain all results, then let the pipeline empty before touching registers
    task automatic drain();
        while (hits_due.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic send_ray(input logic [6*PW-1:0] ray, input logic known, input t_hit hit);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= ray;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        hits_due.push_back(known ? hit : trace_ray(ray));
    endtask

    function automatic longint rnd_signed(input int w);
        case ($urandom_range(5))
            0: return -(longint'(1) <<< (w - 1));
            1: return (longint'(1) <<< (w - 1)) - 1;
            2: return longint'($urandom_range(0, 2000)) - 1000;
            default: return sx($urandom, w);
        endcase
    endfunction

    // random ray aimed near the centre of the current square
    function automatic logic [6*PW-1:0] aimed_ray();
        longint c[3], n[3], o[3], d[3], s;
        for (int k = 0; k < 3; k++) begin
            c[k] = sx(sq_center[k*PW +: PW], PW);
            n[k] = sx(sq_normal[k*DW +: DW], DW);
            s = longint'($urandom_range(0, 8000)) - 4000;
            o[k] = clamp_pos(c[k] + (n[k] * s >>> DFB) + longint'($urandom_range(0, 800)) - 400);
            d[k] = -(n[k] * (s < 0 ? -1 : 1)) + longint'($urandom_range(0, 60000)) - 30000;
            d[k] = d[k] > 524287 ? 524287 : (d[k] < -524288 ? -524288 : d[k]);
        end
        return mk_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
    endfunction

    task automatic set_square(input int mode);
        longint one;
        one = longint'(1) <<< DFB;
        case (mode)
            0: begin
                write_reg(CFG_CENTER, vec3(0, 0, 0, PW));
                write_reg(CFG_NORMAL, vec3(0, 0, one, DW));
                write_reg(CFG_UP, vec3(0, one, 0, DW));
                write_reg(CFG_RIGHT, vec3(one, 0, 0, DW));
                write_reg(CFG_HALF, 60'd1024);
                write_reg(CFG_DEPS, 60'd1);
                write_reg(CFG_TEPS, 60'd0);
            end
            1: begin
                write_reg(CFG_CENTER, vec3(5000, -3000, 2048, PW));
                write_reg(CFG_NORMAL, vec3(one, 0, 0, DW));
                write_reg(CFG_UP, vec3(0, 0, one, DW));
                write_reg(CFG_RIGHT, vec3(0, one, 0, DW));
                write_reg(CFG_HALF, 60'hFFFFF);
                write_reg(CFG_DEPS, 60'd0);
                write_reg(CFG_TEPS, 60'hFFFFF);
            end
            2: begin
                write_reg(CFG_CENTER, vec3(-524288, 524287, 0, PW));
                write_reg(CFG_NORMAL, vec3(0, -one, 0, DW));
                write_reg(CFG_UP, vec3(one, 0, 0, DW));
                write_reg(CFG_RIGHT, vec3(0, 0, one, DW));
                write_reg(CFG_HALF, 60'd0);
                write_reg(CFG_DEPS, 60'h3FFFF);
                write_reg(CFG_TEPS, 60'd5);
            end
            default: begin
                write_reg(CFG_CENTER, CFG_W'({$urandom, $urandom}));
                write_reg(CFG_NORMAL, vec3(185364, 185364, 0, DW));
                write_reg(CFG_UP, vec3(0, 0, one, DW));
                write_reg(CFG_RIGHT, vec3(185364, -185364, 0, DW));
                write_reg(CFG_HALF, 60'($urandom_range(0, 40000)));
                write_reg(CFG_DEPS, 60'($urandom_range(0, 300)));
                write_reg(CFG_TEPS, 60'($urandom_range(0, 50)));
            end
        endcase
    endtask

    // result side: random back-pressure and in-order check
    always @(posedge i_clk) begin
        t_hit got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = {o_m_tuser[0], o_m_tdata[PW-1:0], o_m_tdata[2*PW-1:PW],
                   o_m_tdata[3*PW-1:2*PW], o_m_tdata[4*PW-1:3*PW]};
            if (hits_due.size() == 0) begin
                $error("hit record with none outstanding");
                n_fail++;
            end else begin
                want = hits_due.pop_front();
                if (got.is_hit !== want.is_hit) begin
                    $error("is_hit exp %0d got %0d", want.is_hit, got.is_hit); n_fail++;
                end
                if (got.hdist !== want.hdist) begin
                    $error("hit_distance exp %0h got %0h", want.hdist, got.hdist); n_fail++;
                end
                if (got.px !== want.px) begin
                    $error("point_x exp %0h got %0h", want.px, got.px); n_fail++;
                end
                if (got.py !== want.py) begin
                    $error("point_y exp %0h got %0h", want.py, got.py); n_fail++;
                end
                if (got.pz !== want.pz) begin
                    $error("point_z exp %0h got %0h", want.pz, got.pz); n_fail++;
                end
            end
        end
        i_m_tready <= !(stall_pct != 0 && $urandom_range(99) < stall_pct);
    end

    // watchdog on cycles with no transaction
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("[ray_square_intersect] ERROR");
            $finish;
        end
    end

    t_row rows[$];
    initial begin
        t_row rw;
        longint one;
        one = longint'(1) <<< DFB;
        sq_center = '0;
        sq_normal = vec3(0, 0, one, DW);
        sq_up = vec3(0, one, 0, DW);
        sq_right = vec3(one, 0, 0, DW);
        sq_half = 20'd1024;
        sq_deps = 18'd1;
        sq_teps = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // straight down onto the default unit square from z = 1.0
        rw.ray = mk_ray(0, 0, 1024, 0, 0, -one); rw.known = 1;
        rw.hit = '{1'b1, 20'd1024, 20'd0, 20'd0, 20'd0}; rows.push_back(rw);
        // parallel to plane: denominator too small
        rw.ray = mk_ray(0, 0, 1024, one, 0, 0); rw.hit = '0; rows.push_back(rw);
        // pointing away: t negative
        rw.ray = mk_ray(0, 0, 1024, 0, 0, one); rows.push_back(rw);
        // origin on the plane: numerator zero
        rw.ray = mk_ray(0, 0, 0, 0, 0, -one); rows.push_back(rw);
        // outside the square
        rw.ray = mk_ray(4096, 0, 1024, 0, 0, -one); rows.push_back(rw);
        // square edge exactly at half size
        rw.ray = mk_ray(1024, -1024, 1024, 0, 0, -one); rw.hit = '{1'b1, 20'd1024,
            20'd1024, -20'sd1024, 20'd0}; rows.push_back(rw);
        rw.known = 0;
        rw.ray = mk_ray(-524288, -524288, -524288, -524288, -524288, -524288); rows.push_back(rw);
        rw.ray = mk_ray(524287, 524287, 524287, 524287, 524287, 524287); rows.push_back(rw);
        rw.ray = mk_ray(0, 0, 524287, 0, 0, -1); rows.push_back(rw);
        rw.ray = mk_ray(0, 0, -524288, 0, 0, 2); rows.push_back(rw);
        rw.ray = mk_ray(0, 0, 100, 3, 0, -2); rows.push_back(rw);
        rw.ray = mk_ray(500, 500, 5, 0, 0, -524288); rows.push_back(rw);
        rw.ray = {6*PW{1'b1}}; rows.push_back(rw);
        rw.ray = '0; rows.push_back(rw);
        foreach (rows[i]) send_ray(rows[i].ray, rows[i].known, rows[i].hit);
        i_s_tvalid <= 1'b0;
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            set_square(ph % 4 == 0 && ph != 0 ? 3 : ph % 4);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 79; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 79; end
                default: begin idle_pct = 20; stall_pct = 20; end
            endcase
            for (int i = 0; i < 155; i++) begin
                if ($urandom_range(9) < 7) send_ray(aimed_ray(), 0, '0);
                else send_ray(mk_ray(rnd_signed(PW), rnd_signed(PW), rnd_signed(PW),
                        rnd_signed(DW), rnd_signed(DW), rnd_signed(DW)), 0, '0);
            end
            i_s_tvalid <= 1'b0;
            drain();
        end
        // an index past the last register must leave the square alone
        i_cfg_we <= 1'b1;
        i_cfg_idx <= 3'd7;
        i_cfg_data <= '1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        idle_pct = 0; stall_pct = 0;
        for (int i = 0; i < 20; i++) send_ray(aimed_ray(), 0, '0);
        i_s_tvalid <= 1'b0;
        drain();

        if (n_fail == 0) begin
            $display("[ray_square_intersect] OK");
        end else begin
            $display("[ray_square_intersect] ERROR");
        end
        $finish;
    end
endmodule

// File: filelist.f
src/rsi_pkg.sv
src/rsi_dot.sv
src/rsi_div.sv
src/rsi_point.sv
src/ray_square_intersect.sv
sim/tb.sv
